// ===== rtl/rsfc_pkg.sv =====
`default_nettype none

package rsfc_pkg;

    // Default geometry of the position and direction fields
    localparam int POS_BITS_DEF      = 24;
    localparam int DIR_FRAC_BITS_DEF = 14;

    // Sphere radius after reset, cut to the register width where it is used
    localparam logic [31:0] RADIUS_RESET = 32'd999999;

    // Round a bit count up to whole bytes
    function automatic int byte_round(input int bits);
        return ((bits + 7) / 8) * 8;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/ray_sphere_far_clip.sv =====
`default_nettype none

// Clips each ray against a range sphere and returns the far exit point.
// An input word carries origin O, unit direction D (signed Q2.DIR_FRAC_BITS)
// and sphere centre C; the radius R comes from the configuration channel
// (999999 after reset) and must only be written while no word is in flight.
// With V = C - O and t = floor(V.D), a word hits when V.D >= 0 and
// |V|^2 - t^2 <= R^2; the point is then O + (t + floor(sqrt(R^2 - |V|^2 + t^2))) * D,
// otherwise O + R * D with hit = 0. Products with D are floored by 2^DIR_FRAC_BITS
// and every coordinate saturates to POS_BITS. One word is accepted per clock
// while the spare output slot is free; s_tready drops while it holds a word.
// S_W is the root width (POS_BITS + 5), set by the square root
// that resolves one root bit per pipeline stage. A two-entry output buffer
// keeps input acceptance going while one result waits on m_tready.
module ray_sphere_far_clip
    import rsfc_pkg::*;
#(
    parameter int POS_BITS      = POS_BITS_DEF,
    parameter int DIR_FRAC_BITS = DIR_FRAC_BITS_DEF,
    localparam int IN_W  = byte_round(6 * POS_BITS + 3 * (DIR_FRAC_BITS + 2)),
    localparam int OUT_W = byte_round(3 * POS_BITS)
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,

    // Radius register write
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic [POS_BITS-2:0] cfg_data,      // sphere_radius

    // Ray words
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z, centre_x, centre_y, centre_z
    input  wire logic [IN_W-1:0]     s_tdata,

    // Clip results
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    output logic [OUT_W-1:0]         m_tdata,       // point_x, point_y, point_z
    output logic [0:0]               m_tuser        // hit
);

    localparam int P       = POS_BITS;
    localparam int F       = DIR_FRAC_BITS;
    localparam int D       = F + 2;
    localparam int R_W     = P - 1;
    localparam int V_W     = P + 1;
    localparam int PD_W    = V_W + D;
    localparam int DOT_W   = PD_W + 2;
    localparam int T_W     = DOT_W - 1 - F;
    localparam int SQ_W    = 2 * V_W;
    localparam int VV_W    = SQ_W + 2;
    localparam int TT_W    = 2 * T_W;
    localparam int RR_W    = 2 * R_W;
    localparam int RHS_W   = ((TT_W > RR_W) ? TT_W : RR_W) + 1;
    localparam int S_W     = (RHS_W + 1) / 2;
    localparam int RAD_W   = 2 * S_W;
    localparam int REM_W   = S_W + 3;
    localparam int TS_W    = (T_W > S_W) ? T_W : S_W;
    localparam int DIST_W  = ((TS_W > R_W) ? TS_W : R_W) + 1;
    localparam int PR_W    = DIST_W + 1 + D;
    localparam int SUM_W   = PR_W + 1;
    localparam int OD_W    = 3 * P + 3 * D;
    localparam int NSTG    = S_W + 9;
    localparam int SQ_LAST = 5 + S_W;
    localparam logic [R_W-1:0] RADIUS_INIT = RADIUS_RESET[R_W-1:0];

    // Clamp a widened coordinate back into POS_BITS
    function automatic logic [P-1:0] sat_pos(input logic signed [SUM_W-1:0] val);
        logic [SUM_W-P:0] upper;
        upper = val[SUM_W-1:P-1];
        if ((&upper) || !(|upper)) begin
            return val[P-1:0];
        end else if (val[SUM_W-1]) begin
            return {1'b1, {(P-1){1'b0}}};
        end else begin
            return {1'b0, {(P-1){1'b1}}};
        end
    endfunction

    // Control
    logic            en;
    logic [NSTG-1:0] vld_reg;
    logic [R_W-1:0]  radius_reg;

    // Stage A: V = C - O
    logic signed [V_W-1:0]  a_v_next [3];
    logic signed [V_W-1:0]  a_v_reg  [3];
    logic [OD_W-1:0]        a_od_reg;

    // Stage B: V*D and V*V
    logic signed [PD_W-1:0] b_vd_next [3];
    logic signed [PD_W-1:0] b_vd_reg  [3];
    logic signed [SQ_W-1:0] b_sq_next [3];
    logic [SQ_W-1:0]        b_vv_reg  [3];
    logic [OD_W-1:0]        b_od_reg;

    // Stage C: dot product and |V|^2
    logic signed [DOT_W-1:0] c_dot_next;
    logic signed [DOT_W-1:0] c_dot_reg;
    logic [VV_W-1:0]         c_vv_next;
    logic [VV_W-1:0]         c_vv_reg;
    logic [OD_W-1:0]         c_od_reg;

    // Stage D: t, t^2 and R^2
    logic [T_W-1:0]  d_t_next;
    logic [T_W-1:0]  d_t_reg;
    logic [TT_W-1:0] d_tt_next;
    logic [TT_W-1:0] d_tt_reg;
    logic [RR_W-1:0] d_rr_next;
    logic [RR_W-1:0] d_rr_reg;
    logic            d_neg_reg;
    logic [VV_W-1:0] d_vv_reg;
    logic [OD_W-1:0] d_od_reg;

    // Stage E: R^2 + t^2
    logic [RHS_W-1:0] e_rhs_next;
    logic [RHS_W-1:0] e_rhs_reg;
    logic [T_W-1:0]   e_t_reg;
    logic             e_neg_reg;
    logic [VV_W-1:0]  e_vv_reg;
    logic [OD_W-1:0]  e_od_reg;

    // Square root stages, entry 0 holds the compare result and radicand
    logic [RHS_W:0]   diff_next;
    logic [REM_W-1:0] sq_rem_reg  [S_W+1];
    logic [S_W-1:0]   sq_root_reg [S_W+1];
    logic [RAD_W-1:0] sq_rad_reg  [S_W+1];
    logic [T_W-1:0]   sq_t_reg    [S_W+1];
    logic             sq_hit_reg  [S_W+1];
    logic [OD_W-1:0]  sq_od_reg   [S_W+1];

    // Stage G: travel distance
    logic [DIST_W-1:0] g_dist_next;
    logic [DIST_W-1:0] g_dist_reg;
    logic              g_hit_reg;
    logic [OD_W-1:0]   g_od_reg;

    // Stage H: distance times direction
    logic signed [PR_W-1:0] h_pr_next [3];
    logic signed [PR_W-1:0] h_pr_reg  [3];
    logic                   h_hit_reg;
    logic [3*P-1:0]         h_o_reg;

    // Stage P: saturated point
    logic signed [SUM_W-1:0] p_sum [3];
    logic [3*P-1:0]          p_pt_next;
    logic [3*P-1:0]          p_pt_reg;
    logic                    p_hit_reg;

    // Output buffer
    logic           push;
    logic           pop;
    logic           out_vld_reg;
    logic           out_vld_next;
    logic           sp_vld_reg;
    logic           sp_vld_next;
    logic [3*P-1:0] out_pt_reg;
    logic [3*P-1:0] out_pt_next;
    logic           out_hit_reg;
    logic           out_hit_next;
    logic [3*P-1:0] sp_pt_reg;
    logic [3*P-1:0] sp_pt_next;
    logic           sp_hit_reg;
    logic           sp_hit_next;

    // Advance the whole pipeline while the spare slot is free
    assign en        = !sp_vld_reg;
    assign s_tready  = en;
    assign cfg_ready = 1'b1;

    // Hold the radius register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radius_reg <= RADIUS_INIT;
        end else if (cfg_valid) begin
            radius_reg <= cfg_data;
        end
    end

    // Shift valid bits along with the words
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[NSTG-2:0], s_tvalid};
        end
    end

    // Form V and the per-axis products
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            a_v_next[i] = V_W'($signed(s_tdata[3*P + 3*D + i*P +: P]))
                        - V_W'($signed(s_tdata[i*P +: P]));
            b_vd_next[i] = a_v_reg[i] * $signed(a_od_reg[3*P + i*D +: D]);
            b_sq_next[i] = a_v_reg[i] * a_v_reg[i];
        end
    end

    // Sum the dot product and |V|^2
    always_comb begin
        c_dot_next = DOT_W'(b_vd_reg[0]) + DOT_W'(b_vd_reg[1]) + DOT_W'(b_vd_reg[2]);
        c_vv_next  = VV_W'(b_vv_reg[0]) + VV_W'(b_vv_reg[1]) + VV_W'(b_vv_reg[2]);
    end

    // Take t from the non-negative dot product, square t and R, form R^2 + t^2 - |V|^2
    always_comb begin
        d_t_next   = c_dot_reg[DOT_W-2:F];
        d_tt_next  = TT_W'(d_t_next) * TT_W'(d_t_next);
        d_rr_next  = RR_W'(radius_reg) * RR_W'(radius_reg);
        e_rhs_next = RHS_W'(d_tt_reg) + RHS_W'(d_rr_reg);
        diff_next  = {1'b0, e_rhs_reg} - (RHS_W + 1)'(e_vv_reg);
    end

    // Front stages
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                a_v_reg[i]  <= a_v_next[i];
                b_vd_reg[i] <= b_vd_next[i];
                b_vv_reg[i] <= b_sq_next[i];
            end
            a_od_reg  <= s_tdata[OD_W-1:0];
            b_od_reg  <= a_od_reg;
            c_dot_reg <= c_dot_next;
            c_vv_reg  <= c_vv_next;
            c_od_reg  <= b_od_reg;
            d_t_reg   <= d_t_next;
            d_tt_reg  <= d_tt_next;
            d_rr_reg  <= d_rr_next;
            d_neg_reg <= c_dot_reg[DOT_W-1];
            d_vv_reg  <= c_vv_reg;
            d_od_reg  <= c_od_reg;
            e_rhs_reg <= e_rhs_next;
            e_t_reg   <= d_t_reg;
            e_neg_reg <= d_neg_reg;
            e_vv_reg  <= d_vv_reg;
            e_od_reg  <= d_od_reg;
            // Hit when ahead and |V|^2 <= R^2 + t^2; the difference feeds the root
            sq_rem_reg[0]  <= '0;
            sq_root_reg[0] <= '0;
            sq_rad_reg[0]  <= RAD_W'(diff_next[RHS_W-1:0]);
            sq_t_reg[0]    <= e_t_reg;
            sq_hit_reg[0]  <= !e_neg_reg && !diff_next[RHS_W];
            sq_od_reg[0]   <= e_od_reg;
        end
    end

    // Resolve one root bit per stage
    for (genvar k = 0; k < S_W; k++) begin : g_root
        logic [REM_W-1:0] rem_sh;
        logic [REM_W-1:0] trial;
        logic [REM_W-1:0] step_rem_next;
        logic [S_W-1:0]   step_root_next;

        always_comb begin
            rem_sh = {sq_rem_reg[k][REM_W-3:0], sq_rad_reg[k][RAD_W-1 -: 2]};
            trial  = REM_W'({sq_root_reg[k], 2'b01});
            if (rem_sh >= trial) begin
                step_rem_next  = rem_sh - trial;
                step_root_next = {sq_root_reg[k][S_W-2:0], 1'b1};
            end else begin
                step_rem_next  = rem_sh;
                step_root_next = {sq_root_reg[k][S_W-2:0], 1'b0};
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                sq_rem_reg[k+1]  <= step_rem_next;
                sq_root_reg[k+1] <= step_root_next;
                sq_rad_reg[k+1]  <= {sq_rad_reg[k][RAD_W-3:0], 2'b00};
                sq_t_reg[k+1]    <= sq_t_reg[k];
                sq_hit_reg[k+1]  <= sq_hit_reg[k];
                sq_od_reg[k+1]   <= sq_od_reg[k];
            end
        end
    end

    // Pick the travel distance, scale the direction, add and clamp
    always_comb begin
        if (sq_hit_reg[S_W]) begin
            g_dist_next = DIST_W'(sq_t_reg[S_W]) + DIST_W'(sq_root_reg[S_W]);
        end else begin
            g_dist_next = DIST_W'(radius_reg);
        end
        for (int i = 0; i < 3; i++) begin
            h_pr_next[i] = $signed({1'b0, g_dist_reg}) * $signed(g_od_reg[3*P + i*D +: D]);
            p_sum[i] = SUM_W'($signed(h_o_reg[i*P +: P])) + SUM_W'(h_pr_reg[i] >>> F);
            p_pt_next[i*P +: P] = sat_pos(p_sum[i]);
        end
    end

    // Back stages
    always_ff @(posedge aclk) begin
        if (en) begin
            g_dist_reg <= g_dist_next;
            g_hit_reg  <= sq_hit_reg[S_W];
            g_od_reg   <= sq_od_reg[S_W];
            for (int i = 0; i < 3; i++) begin
                h_pr_reg[i] <= h_pr_next[i];
            end
            h_hit_reg <= g_hit_reg;
            h_o_reg   <= g_od_reg[3*P-1:0];
            p_pt_reg  <= p_pt_next;
            p_hit_reg <= h_hit_reg;
        end
    end

    // Output buffer: main slot drives the port, spare slot catches a stalled word
    assign push = en && vld_reg[NSTG-1];
    assign pop  = out_vld_reg && m_tready;

    always_comb begin
        out_vld_next = out_vld_reg;
        out_pt_next  = out_pt_reg;
        out_hit_next = out_hit_reg;
        sp_vld_next  = sp_vld_reg;
        sp_pt_next   = sp_pt_reg;
        sp_hit_next  = sp_hit_reg;
        if (pop || !out_vld_reg) begin
            if (sp_vld_reg) begin
                out_vld_next = 1'b1;
                out_pt_next  = sp_pt_reg;
                out_hit_next = sp_hit_reg;
                sp_vld_next  = push;
                sp_pt_next   = p_pt_reg;
                sp_hit_next  = p_hit_reg;
            end else begin
                out_vld_next = push;
                out_pt_next  = p_pt_reg;
                out_hit_next = p_hit_reg;
                sp_vld_next  = 1'b0;
            end
        end else if (push) begin
            sp_vld_next = 1'b1;
            sp_pt_next  = p_pt_reg;
            sp_hit_next = p_hit_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
            sp_vld_reg  <= 1'b0;
        end else begin
            out_vld_reg <= out_vld_next;
            sp_vld_reg  <= sp_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_pt_reg  <= out_pt_next;
        out_hit_reg <= out_hit_next;
        sp_pt_reg   <= sp_pt_next;
        sp_hit_reg  <= sp_hit_next;
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = OUT_W'(out_pt_reg);
    assign m_tuser  = out_hit_reg;

    // Spare slot only fills behind a held main slot
    a_spare_behind_main: assert property (@(posedge aclk) disable iff (!aresetn)
        sp_vld_reg |-> out_vld_reg)
        else $error("spare slot valid while main slot empty");

    // A stalled pipeline keeps every word in place
    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        !en |=> $stable(vld_reg))
        else $error("pipeline valid bits moved during stall");

    // Final root remainder never exceeds twice the root
    a_root_remainder: assert property (@(posedge aclk) disable iff (!aresetn)
        vld_reg[SQ_LAST] |-> (sq_rem_reg[S_W] <= REM_W'({sq_root_reg[S_W], 1'b0})))
        else $error("square root remainder out of range");

    // Radius comes out of reset at its default
    a_radius_reset: assert property (@(posedge aclk)
        $rose(aresetn) |-> (radius_reg == RADIUS_INIT))
        else $error("radius not at reset value");

endmodule

`default_nettype wire
